>>> hdl/hessian_line_center_extract_assert.svh
// Assertion macros used by the line center extractor RTL.
`ifndef HESSIAN_LINE_CENTER_EXTRACT_ASSERT_SVH
`define HESSIAN_LINE_CENTER_EXTRACT_ASSERT_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define HLCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk outside reset.
`define HLCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/hlce_pkg.sv
// Package with widths, stage indexes, register codes and the pipeline context type.
package hlce_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 8;
  localparam int LINE_W    = 2 * PIX_W + 1;
  localparam int FRAC_BITS = 8;
  localparam int X_W       = 20;
  localparam int Y_W       = 21;

  // Square root of N * 2^SQ_SHIFT gives sqrt(N) with 8 fractional bits
  localparam int N2_W      = 21;
  localparam int SQ_SHIFT  = 16;
  localparam int SQ_REM_W  = N2_W + SQ_SHIFT;
  localparam int SQ_BITS   = (SQ_REM_W + 1) / 2;
  localparam int SQ_TRY_W  = SQ_REM_W + 2;

  localparam int PROD_W    = 36;
  localparam int DEN_W     = 38;
  localparam int Q_W       = FRAC_BITS;
  localparam int DIV_W     = PROD_W + FRAC_BITS + 2;

  // Pipeline stage indexes
  localparam int ST_MEM  = 0;
  localparam int ST_DER  = 1;
  localparam int ST_SQR  = 2;
  localparam int ST_N2   = 3;
  localparam int ST_SQ0  = 4;
  localparam int ST_EIG  = ST_SQ0 + SQ_BITS;
  localparam int ST_NRM  = ST_EIG + 1;
  localparam int ST_PRD  = ST_NRM + 1;
  localparam int ST_SUM  = ST_PRD + 1;
  localparam int ST_DEN  = ST_SUM + 1;
  localparam int ST_CHK  = ST_DEN + 1;
  localparam int ST_DV0  = ST_CHK + 1;
  localparam int ST_LAST = ST_DV0 + Q_W - 1;
  localparam int NST     = ST_LAST + 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

  typedef struct packed {
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic [PIX_W-1:0]          pix;
    logic                      mbit;
    logic                      border;
    logic                      ok;
    logic signed [8:0]         fx;
    logic signed [8:0]         fy;
    logic signed [9:0]         fxx;
    logic signed [9:0]         fyy;
    logic signed [9:0]         fxy;
    logic signed [10:0]        d;
    logic signed [10:0]        sum;
    logic [20:0]               dd;
    logic [17:0]               ff;
    logic [N2_W-1:0]           n2;
    logic [SQ_REM_W-1:0]       srem;
    logic [SQ_BITS-1:0]        root;
    logic signed [21:0]        nx_raw;
    logic signed [21:0]        ny_raw;
    logic signed [12:0]        nx;
    logic signed [12:0]        ny;
    logic signed [25:0]        nxx;
    logic signed [25:0]        nyy;
    logic signed [25:0]        nxy;
    logic signed [21:0]        ax;
    logic signed [21:0]        ay;
    logic signed [22:0]        num;
    logic signed [PROD_W-1:0]  t1;
    logic signed [PROD_W-1:0]  t2;
    logic signed [PROD_W-1:0]  t3;
    logic signed [DEN_W-1:0]   den;
    logic signed [PROD_W-1:0]  px;
    logic signed [PROD_W-1:0]  py;
    logic [DIV_W-1:0]          rem_x;
    logic [DIV_W-1:0]          rem_y;
    logic [DIV_W-1:0]          dvs;
    logic                      neg_x;
    logic                      neg_y;
    logic [Q_W-1:0]            qx;
    logic [Q_W-1:0]            qy;
  } ctx_t;

endpackage

>>> hdl/hessian_line_center_extract.sv
// Hessian ridge center extractor: line store, derivative window and subpixel pipeline.
//
//  channel   direction  handshake            payload
//  in_       in         in_valid / in_stall  in_pixel, in_mask_bit, in_frame_start
//  out_      out        out_valid / out_stall out_point_x, out_point_y
//  cfg_      in         cfg_wr_en            cfg_index, cfg_wr_data
//
// One pixel per clock while in_stall is low; a point passes the pipeline stages, then the output register.
// The rate is set by the single line store, read and written once per pixel.
// rst_n (synchronous) clears counters, window, forward flag, pipeline and output valids and loads 640 x 480.
// The line store is not cleared; rows are written before they are read.
// out_stall holds the output register; empty stages keep filling until the pipe is full.
// in_stall rises only when every stage holds an item and the output is stalled.
module hessian_line_center_extract (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [hlce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hlce_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hlce_pkg::PIX_W-1:0]    in_pixel,
  input  logic                          in_mask_bit,
  input  logic                          in_frame_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hlce_pkg::X_W-1:0]      out_point_x,
  output logic [hlce_pkg::Y_W-1:0]      out_point_y
);
  import hlce_pkg::*;

  // Configuration
  logic [CFG_W-1:0] width_r, height_r, w_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMAGE_WIDTH_RST;
      height_r <= IMAGE_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wr_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (width_r > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_r;

  // Handshake and stage advance chain
  logic             in_accept, adv_out;
  logic [NST-1:0]   v_r, adv;
  ctx_t             st_r   [NST];
  ctx_t             st_nxt [NST];

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = !adv[ST_MEM];
  assign adv_out   = !out_valid || !out_stall;

  always_comb begin
    adv[ST_LAST] = !v_r[ST_LAST] || adv_out;
    for (int k = ST_LAST - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  // Position counters
  logic [COL_W-1:0] col_r, col_nxt, c_cur;
  logic [ROW_W-1:0] row_r, row_nxt, r_cur;
  logic [CFG_W:0]   c_inc;
  logic [ROW_W:0]   r_inc;
  logic             border;

  always_comb begin
    c_cur   = in_frame_start ? '0 : col_r;
    r_cur   = in_frame_start ? '0 : row_r;
    c_inc   = (CFG_W+1)'(c_cur) + (CFG_W+1)'(1);
    r_inc   = (ROW_W+1)'(r_cur) + (ROW_W+1)'(1);
    col_nxt = c_inc[COL_W-1:0];
    row_nxt = r_cur;
    if (c_inc >= (CFG_W+1)'(w_eff)) begin
      col_nxt = '0;
      row_nxt = (r_inc >= (ROW_W+1)'(height_r)) ? '0 : r_inc[ROW_W-1:0];
    end
    border = (r_cur >= ROW_W'(3)) &&
             ((ROW_W+1)'(r_cur) + (ROW_W+1)'(2) <= (ROW_W+1)'(height_r)) &&
             (c_cur >= COL_W'(3)) &&
             ((CFG_W+1)'(c_cur) + (CFG_W+1)'(2) <= (CFG_W+1)'(w_eff));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line store: {upper, center, mask} per column, one read and one write a cycle
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] mem_q_r, fwd_q_r, line_q, wr_data;
  logic              fwd_hit_r, wr_en;
  logic [COL_W-1:0]  wr_addr;
  logic [PIX_W-1:0]  up_c, cen_c;
  logic              msk_c;

  assign line_q  = fwd_hit_r ? fwd_q_r : mem_q_r;
  assign up_c    = line_q[LINE_W-1 -: PIX_W];
  assign cen_c   = line_q[PIX_W -: PIX_W];
  assign msk_c   = line_q[0];
  assign wr_en   = v_r[ST_MEM] && adv[ST_DER];
  assign wr_addr = st_r[ST_MEM].col;
  assign wr_data = {cen_c, st_r[ST_MEM].pix, st_r[ST_MEM].mbit};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (in_accept) begin
      mem_q_r <= line_mem[c_cur];
    end
  end

  // Forward the entry written in the same cycle as a read of that column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_accept) begin
      fwd_hit_r <= wr_en && (wr_addr == c_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fwd_q_r <= wr_data;
    end
  end

  // Window: row r at c-1, row r-1 at c-2 and c-1, row r-2 at c-1, mask of row r-1
  logic [PIX_W-1:0] win_nxt_r, win_m2_r, win_m1_r, win_up_r;
  logic             win_msk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_nxt_r <= '0;
      win_m2_r  <= '0;
      win_m1_r  <= '0;
      win_up_r  <= '0;
      win_msk_r <= 1'b0;
    end else if (wr_en) begin
      win_nxt_r <= st_r[ST_MEM].pix;
      win_m2_r  <= win_m1_r;
      win_m1_r  <= cen_c;
      win_up_r  <= up_c;
      win_msk_r <= msk_c;
    end
  end

  // Stage logic
  logic signed [10:0]       sv_pix, sv_cen, sv_nxt, sv_m1, sv_m2, sv_up;
  logic signed [10:0]       fx_w, fy_w, fxx_w, fyy_w, fxy_w, d_w, sum_w;
  logic signed [21:0]       dd_w;
  logic signed [19:0]       ff_w;
  logic [N2_W-1:0]          n2_w;
  logic [SQ_TRY_W-1:0]      sq_try;
  logic signed [21:0]       d256, f512, qs;
  logic [21:0]              mx_w, my_w, m_or;
  logic [4:0]               bl, shamt;
  logic [11:0]              mxs, mys;
  logic signed [25:0]       nxx_w, nyy_w, nxy_w;
  logic signed [21:0]       ax_w, ay_w;
  logic signed [PROD_W-1:0] t1_w, t2_w, t3_w, px_w, py_w;
  logic [DEN_W-1:0]         dm_w;
  logic [PROD_W-1:0]        ux_w, uy_w;
  logic [DIV_W-1:0]         dv_try;

  always_comb begin
    // column read stage
    st_nxt[ST_MEM]        = '0;
    st_nxt[ST_MEM].row    = r_cur;
    st_nxt[ST_MEM].col    = c_cur;
    st_nxt[ST_MEM].pix    = in_pixel;
    st_nxt[ST_MEM].mbit   = in_mask_bit;
    st_nxt[ST_MEM].border = border;

    // first and second differences
    sv_pix = $signed({3'b000, st_r[ST_MEM].pix});
    sv_cen = $signed({3'b000, cen_c});
    sv_nxt = $signed({3'b000, win_nxt_r});
    sv_m1  = $signed({3'b000, win_m1_r});
    sv_m2  = $signed({3'b000, win_m2_r});
    sv_up  = $signed({3'b000, win_up_r});
    fx_w   = sv_cen - sv_m1;
    fy_w   = sv_nxt - sv_m1;
    fxx_w  = sv_cen - (sv_m1 <<< 1) + sv_m2;
    fyy_w  = sv_nxt - (sv_m1 <<< 1) + sv_up;
    fxy_w  = sv_pix - sv_cen - sv_nxt + sv_m1;
    st_nxt[ST_DER]     = st_r[ST_MEM];
    st_nxt[ST_DER].fx  = fx_w[8:0];
    st_nxt[ST_DER].fy  = fy_w[8:0];
    st_nxt[ST_DER].fxx = fxx_w[9:0];
    st_nxt[ST_DER].fyy = fyy_w[9:0];
    st_nxt[ST_DER].fxy = fxy_w[9:0];
    st_nxt[ST_DER].ok  = win_msk_r && st_r[ST_MEM].border;

    // trace difference, trace and squares
    d_w   = 11'($signed(st_r[ST_DER].fxx)) - 11'($signed(st_r[ST_DER].fyy));
    sum_w = 11'($signed(st_r[ST_DER].fxx)) + 11'($signed(st_r[ST_DER].fyy));
    dd_w  = d_w * d_w;
    ff_w  = $signed(st_r[ST_DER].fxy) * $signed(st_r[ST_DER].fxy);
    st_nxt[ST_SQR]     = st_r[ST_DER];
    st_nxt[ST_SQR].d   = d_w;
    st_nxt[ST_SQR].sum = sum_w;
    st_nxt[ST_SQR].dd  = dd_w[20:0];
    st_nxt[ST_SQR].ff  = ff_w[17:0];

    // discriminant
    n2_w = st_r[ST_SQR].dd + N2_W'({st_r[ST_SQR].ff, 2'b00});
    st_nxt[ST_N2]      = st_r[ST_SQR];
    st_nxt[ST_N2].n2   = n2_w;
    st_nxt[ST_N2].srem = {n2_w, SQ_SHIFT'(0)};
    st_nxt[ST_N2].root = '0;

    // square root, one result bit per stage
    for (int k = 0; k < SQ_BITS; k++) begin
      st_nxt[ST_SQ0+k] = st_r[ST_SQ0+k-1];
      sq_try = (SQ_TRY_W'(st_r[ST_SQ0+k-1].root) << (SQ_BITS - k)) +
               (SQ_TRY_W'(1) << (2 * (SQ_BITS - 1 - k)));
      if (SQ_TRY_W'(st_r[ST_SQ0+k-1].srem) >= sq_try) begin
        st_nxt[ST_SQ0+k].srem = st_r[ST_SQ0+k-1].srem - sq_try[SQ_REM_W-1:0];
        st_nxt[ST_SQ0+k].root = st_r[ST_SQ0+k-1].root | (SQ_BITS'(1) << (SQ_BITS - 1 - k));
      end
    end

    // eigenvector of the dominant eigenvalue; on a tie take the second
    d256 = 22'($signed(st_r[ST_EIG-1].d)) <<< 8;
    f512 = 22'($signed(st_r[ST_EIG-1].fxy)) <<< 9;
    qs   = $signed(22'(st_r[ST_EIG-1].root));
    st_nxt[ST_EIG] = st_r[ST_EIG-1];
    if (st_r[ST_EIG-1].n2 == '0) begin
      st_nxt[ST_EIG].nx_raw = 22'sd0;
      st_nxt[ST_EIG].ny_raw = 22'sd1;
    end else if ($signed(st_r[ST_EIG-1].sum) > 11'sd0) begin
      if (!st_r[ST_EIG-1].d[10]) begin
        st_nxt[ST_EIG].nx_raw = d256 + qs;
        st_nxt[ST_EIG].ny_raw = f512;
      end else begin
        st_nxt[ST_EIG].nx_raw = f512;
        st_nxt[ST_EIG].ny_raw = qs - d256;
      end
    end else begin
      if (st_r[ST_EIG-1].d[10] || st_r[ST_EIG-1].d == '0) begin
        st_nxt[ST_EIG].nx_raw = d256 - qs;
        st_nxt[ST_EIG].ny_raw = f512;
      end else begin
        st_nxt[ST_EIG].nx_raw = f512;
        st_nxt[ST_EIG].ny_raw = 22'sd0 - d256 - qs;
      end
    end

    // scale both magnitudes down together below 4096, keep signs
    mx_w = st_r[ST_EIG].nx_raw[21] ? 22'(22'd0 - st_r[ST_EIG].nx_raw) : st_r[ST_EIG].nx_raw;
    my_w = st_r[ST_EIG].ny_raw[21] ? 22'(22'd0 - st_r[ST_EIG].ny_raw) : st_r[ST_EIG].ny_raw;
    m_or = mx_w | my_w;
    bl   = '0;
    for (int b = 0; b < 22; b++) begin
      if (m_or[b]) bl = 5'(b + 1);
    end
    shamt = (bl > 5'd12) ? bl - 5'd12 : 5'd0;
    mxs   = 12'(mx_w >> shamt);
    mys   = 12'(my_w >> shamt);
    st_nxt[ST_NRM]    = st_r[ST_EIG];
    st_nxt[ST_NRM].nx = st_r[ST_EIG].nx_raw[21] ? 13'd0 - {1'b0, mxs} : {1'b0, mxs};
    st_nxt[ST_NRM].ny = st_r[ST_EIG].ny_raw[21] ? 13'd0 - {1'b0, mys} : {1'b0, mys};

    // products of the vector
    nxx_w = $signed(st_r[ST_NRM].nx) * $signed(st_r[ST_NRM].nx);
    nyy_w = $signed(st_r[ST_NRM].ny) * $signed(st_r[ST_NRM].ny);
    nxy_w = $signed(st_r[ST_NRM].nx) * $signed(st_r[ST_NRM].ny);
    ax_w  = $signed(st_r[ST_NRM].nx) * $signed(st_r[ST_NRM].fx);
    ay_w  = $signed(st_r[ST_NRM].ny) * $signed(st_r[ST_NRM].fy);
    st_nxt[ST_PRD]     = st_r[ST_NRM];
    st_nxt[ST_PRD].nxx = nxx_w;
    st_nxt[ST_PRD].nyy = nyy_w;
    st_nxt[ST_PRD].nxy = nxy_w;
    st_nxt[ST_PRD].ax  = ax_w;
    st_nxt[ST_PRD].ay  = ay_w;

    // numerator and denominator terms
    t1_w = $signed(st_r[ST_PRD].fxx) * $signed(st_r[ST_PRD].nxx);
    t2_w = $signed(st_r[ST_PRD].fxy) * $signed(st_r[ST_PRD].nxy);
    t3_w = $signed(st_r[ST_PRD].fyy) * $signed(st_r[ST_PRD].nyy);
    st_nxt[ST_SUM]     = st_r[ST_PRD];
    st_nxt[ST_SUM].num = 23'($signed(st_r[ST_PRD].ax)) + 23'($signed(st_r[ST_PRD].ay));
    st_nxt[ST_SUM].t1  = t1_w;
    st_nxt[ST_SUM].t2  = t2_w;
    st_nxt[ST_SUM].t3  = t3_w;

    // denominator and scaled offsets
    px_w = $signed(st_r[ST_SUM].num) * $signed(st_r[ST_SUM].nx);
    py_w = $signed(st_r[ST_SUM].num) * $signed(st_r[ST_SUM].ny);
    st_nxt[ST_DEN]     = st_r[ST_SUM];
    st_nxt[ST_DEN].den = DEN_W'($signed(st_r[ST_SUM].t1)) +
                         (DEN_W'($signed(st_r[ST_SUM].t2)) <<< 1) +
                         DEN_W'($signed(st_r[ST_SUM].t3));
    st_nxt[ST_DEN].px  = px_w;
    st_nxt[ST_DEN].py  = py_w;

    // range check and divider setup: q = (2u + dm) / (2dm), u = |p| << FRAC_BITS
    dm_w = st_r[ST_DEN].den[DEN_W-1] ? DEN_W'(0) - st_r[ST_DEN].den : st_r[ST_DEN].den;
    ux_w = st_r[ST_DEN].px[PROD_W-1] ? PROD_W'(0) - st_r[ST_DEN].px : st_r[ST_DEN].px;
    uy_w = st_r[ST_DEN].py[PROD_W-1] ? PROD_W'(0) - st_r[ST_DEN].py : st_r[ST_DEN].py;
    st_nxt[ST_CHK]       = st_r[ST_DEN];
    st_nxt[ST_CHK].ok    = st_r[ST_DEN].ok && (dm_w != '0) &&
                           ((DEN_W'(ux_w) << 1) <= dm_w) && ((DEN_W'(uy_w) << 1) <= dm_w);
    st_nxt[ST_CHK].rem_x = (DIV_W'(ux_w) << (FRAC_BITS + 1)) + DIV_W'(dm_w);
    st_nxt[ST_CHK].rem_y = (DIV_W'(uy_w) << (FRAC_BITS + 1)) + DIV_W'(dm_w);
    st_nxt[ST_CHK].dvs   = DIV_W'(dm_w) << 1;
    st_nxt[ST_CHK].neg_x = (st_r[ST_DEN].px != '0) &&
                           (st_r[ST_DEN].px[PROD_W-1] == st_r[ST_DEN].den[DEN_W-1]);
    st_nxt[ST_CHK].neg_y = (st_r[ST_DEN].py != '0) &&
                           (st_r[ST_DEN].py[PROD_W-1] == st_r[ST_DEN].den[DEN_W-1]);
    st_nxt[ST_CHK].qx    = '0;
    st_nxt[ST_CHK].qy    = '0;

    // restoring division, one quotient bit per stage for both offsets
    for (int k = 0; k < Q_W; k++) begin
      st_nxt[ST_DV0+k] = st_r[ST_DV0+k-1];
      dv_try = st_r[ST_DV0+k-1].dvs << (Q_W - 1 - k);
      if (st_r[ST_DV0+k-1].rem_x >= dv_try) begin
        st_nxt[ST_DV0+k].rem_x = st_r[ST_DV0+k-1].rem_x - dv_try;
        st_nxt[ST_DV0+k].qx    = st_r[ST_DV0+k-1].qx | (Q_W'(1) << (Q_W - 1 - k));
      end
      if (st_r[ST_DV0+k-1].rem_y >= dv_try) begin
        st_nxt[ST_DV0+k].rem_y = st_r[ST_DV0+k-1].rem_y - dv_try;
        st_nxt[ST_DV0+k].qy    = st_r[ST_DV0+k-1].qy | (Q_W'(1) << (Q_W - 1 - k));
      end
    end
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[ST_MEM]) v_r[ST_MEM] <= in_accept;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (adv[k]) st_r[k] <= st_nxt[k];
    end
  end

  // Output register
  logic [X_W-1:0] px_out, ox_out;
  logic [Y_W-1:0] py_out, oy_out;
  logic           out_valid_r;

  always_comb begin
    ox_out = st_r[ST_LAST].neg_x ? X_W'(0) - X_W'(st_r[ST_LAST].qx) : X_W'(st_r[ST_LAST].qx);
    oy_out = st_r[ST_LAST].neg_y ? Y_W'(0) - Y_W'(st_r[ST_LAST].qy) : Y_W'(st_r[ST_LAST].qy);
    px_out = ((X_W'(st_r[ST_LAST].col) - X_W'(1)) << FRAC_BITS) + ox_out;
    py_out = ((Y_W'(st_r[ST_LAST].row) - Y_W'(1)) << FRAC_BITS) + oy_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= v_r[ST_LAST] && st_r[ST_LAST].ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_point_x <= px_out;
      out_point_y <= py_out;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  `include "hessian_line_center_extract_assert.svh"

  `HLCE_ASSERT_IMP(a_stall_only_when_full, in_stall, (&v_r) && out_valid && out_stall, "input stalled with a free stage")
  `HLCE_ASSERT_IMP(a_out_from_good_item, $rose(out_valid), $past(v_r[ST_LAST] && st_r[ST_LAST].ok), "point emitted without a passing item")
  `HLCE_ASSERT_NXT(a_last_stage_holds, v_r[ST_LAST] && !adv[ST_LAST], v_r[ST_LAST] && $stable(st_r[ST_LAST]), "last stage lost its item while blocked")

endmodule
